// ===== hw/rtl/tlc_pkg.sv =====
// ---------------------------------------------------------------------------
// tlc_pkg: shared types and constants
// Payload structs, controller states and command/status groups for the
// threshold linkage clusterer.
// ---------------------------------------------------------------------------
package tlc_pkg;

  localparam int NUM_ITEMS = 256;
  localparam int ITEM_W    = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int SWEEP_W   = $clog2(NUM_ITEMS + 1);
  localparam int IDX_IN_W  = 8;
  localparam int LABEL_W   = 16;
  localparam int DIST_W    = 16;

  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 16'd32768;

  typedef struct packed {
    logic                first_edge;
    logic [IDX_IN_W-1:0] item_a;
    logic [IDX_IN_W-1:0] item_b;
    logic [DIST_W-1:0]   distance;
    logic                last_edge;
  } in_item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label_a;
    logic [LABEL_W-1:0] label_b;
    logic               joined;
    logic               merged;
    logic               last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_DECIDE,
    ST_WR_A,
    ST_WR_B,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_a;
    logic rd_b;
    logic decide;
    logic wr_a;
    logic wr_b;
    logic sweep;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic sweep_done;
  } status_t;

endpackage

// ===== hw/rtl/threshold_linkage_clusterer.sv =====
// ---------------------------------------------------------------------------
// threshold_linkage_clusterer: single-linkage clustering over pair edges
// Input transaction: one edge (first_edge, item_a, item_b, distance,
// last_edge) on in_data, taken at a clock edge with start high and busy low.
// Result transaction: out_data with out_valid high for exactly one cycle;
// the receiver cannot stall, so each result must be taken when shown.
// Configuration: cfg_data (threshold) written when cfg_valid and cfg_ready
// are high; cfg_ready is always high. Write only while busy is low.
// Sequence: after acceptance the controller reads both labels, decides,
// writes new labels where needed and raises the result strobe; busy drops
// the cycle after it. An edge that merges two clusters instead sweeps the
// whole label memory, one entry per cycle through its single read port,
// before the strobe.
// Reset (rst_n low, synchronous): valid bits and label counter clear,
// threshold returns to 32768. The label memory is not cleared; entries are
// read only behind their valid bits, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module threshold_linkage_clusterer
  import tlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIST_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign out_valid = cmd.deliver;

  tlc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  tlc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== hw/rtl/tlc_ctrl.sv =====
// ---------------------------------------------------------------------------
// tlc_ctrl: edge sequencer
// Steps each transaction through label reads, decision, writes or the
// relabel sweep, and the result strobe.
// ---------------------------------------------------------------------------
module tlc_ctrl
  import tlc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd.rd_a  = 1'b1;
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = status.need_sweep ? ST_SWEEP : ST_WR_A;
      end
      ST_WR_A: begin
        cmd.wr_a  = 1'b1;
        state_nxt = ST_WR_B;
      end
      ST_WR_B: begin
        cmd.wr_b  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.deliver = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (busy && cmd.rd_a))
    else $error("accept did not start a read");
  a_deliver_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deliver |=> !busy)
    else $error("not idle after result");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one command active");
`endif

endmodule

// ===== hw/rtl/tlc_datapath.sv =====
// ---------------------------------------------------------------------------
// tlc_datapath: label store and decision logic
// Holds item labels, valid bits, label counter and threshold; computes the
// join decision and performs writes and the relabel sweep.
// ---------------------------------------------------------------------------
module tlc_datapath
  import tlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  cmd_t              cmd,
  output status_t           status,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIST_W-1:0] cfg_data
);

  logic [LABEL_W-1:0] mem [NUM_ITEMS];
  logic [LABEL_W-1:0] rdata_r;
  logic [ITEM_W-1:0]  rd_addr;
  logic               we;
  logic [ITEM_W-1:0]  wr_addr;
  logic [LABEL_W-1:0] wr_data;

  logic [NUM_ITEMS-1:0] valid_r;
  logic [LABEL_W-1:0]   cnt_r, cnt_nxt;
  logic [DIST_W-1:0]    thr_r;

  logic               last_r;
  logic [DIST_W-1:0]  dist_r;
  logic [ITEM_W-1:0]  ia_r, ib_r;
  logic [LABEL_W-1:0] la_r, lb_r;
  logic [LABEL_W-1:0] la_new_r, lb_new_r;
  logic               wa_r, wb_r;
  out_item_t          out_r;

  logic [SWEEP_W-1:0] sw_r;
  logic               swp_r;
  logic [ITEM_W-1:0]  swa_r;
  logic               sw_more;
  logic               sw_hit;

  logic               va, vb, near;
  logic [LABEL_W-1:0] c1, c2, la_n, lb_n;
  logic               wa_n, wb_n, sweep_n;
  logic [1:0]         inc;

  assign cfg_ready = 1'b1;
  assign out_data  = out_r;

  // Decision, valid in the decide cycle: rdata_r holds the label of item b
  always_comb begin
    va      = valid_r[ia_r];
    vb      = valid_r[ib_r];
    near    = dist_r < thr_r;
    c1      = cnt_r + LABEL_W'(1);
    c2      = cnt_r + LABEL_W'(2);
    la_n    = la_r;
    lb_n    = rdata_r;
    wa_n    = 1'b0;
    wb_n    = 1'b0;
    sweep_n = 1'b0;
    inc     = 2'd0;
    if (!near) begin
      wa_n = !va;
      wb_n = !vb;
      inc  = 2'({1'b0, !va}) + 2'({1'b0, !vb});
      la_n = va ? la_r : c1;
      lb_n = vb ? rdata_r : (va ? c1 : c2);
    end else if (va && vb) begin
      if (la_r != rdata_r) begin
        sweep_n = 1'b1;
        inc     = 2'd1;
        la_n    = c1;
        lb_n    = c1;
      end
    end else if (va) begin
      wb_n = 1'b1;
      lb_n = la_r;
    end else if (vb) begin
      wa_n = 1'b1;
      la_n = rdata_r;
    end else begin
      wa_n = 1'b1;
      wb_n = 1'b1;
      inc  = 2'd1;
      la_n = c1;
      lb_n = c1;
    end
    cnt_nxt = cnt_r + LABEL_W'(inc);
  end

  assign status.need_sweep = sweep_n;
  assign status.sweep_done = (sw_r == SWEEP_W'(NUM_ITEMS));

  assign sw_more = (sw_r < SWEEP_W'(NUM_ITEMS));
  assign sw_hit  = swp_r && valid_r[swa_r] && ((rdata_r == la_r) || (rdata_r == lb_r));

  always_comb begin
    rd_addr = ia_r;
    if (cmd.rd_b) begin
      rd_addr = ib_r;
    end else if (cmd.sweep) begin
      rd_addr = sw_r[ITEM_W-1:0];
    end
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = ia_r;
    wr_data = la_new_r;
    if (cmd.wr_a) begin
      we = wa_r;
    end else if (cmd.wr_b) begin
      we      = wb_r;
      wr_addr = ib_r;
      wr_data = lb_new_r;
    end else if (cmd.sweep) begin
      we      = sw_hit;
      wr_addr = swa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      thr_r   <= MAX_DIST_RESET;
      sw_r    <= '0;
      swp_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (cmd.accept && in_data.first_edge) begin
        valid_r <= '0;
      end
      if (cmd.wr_a && wa_r) begin
        valid_r[ia_r] <= 1'b1;
      end
      if (cmd.wr_b && wb_r) begin
        valid_r[ib_r] <= 1'b1;
      end
      if (cmd.decide) begin
        cnt_r <= cnt_nxt;
        sw_r  <= '0;
        swp_r <= 1'b0;
      end
      if (cmd.sweep) begin
        if (sw_more) begin
          sw_r <= sw_r + SWEEP_W'(1);
        end
        swp_r <= sw_more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ia_r   <= ITEM_W'(32'(in_data.item_a) % NUM_ITEMS);
      ib_r   <= ITEM_W'(32'(in_data.item_b) % NUM_ITEMS);
      dist_r <= in_data.distance;
      last_r <= in_data.last_edge;
    end
    if (cmd.rd_b) begin
      la_r <= rdata_r;
    end
    if (cmd.decide) begin
      lb_r           <= rdata_r;
      la_new_r       <= la_n;
      lb_new_r       <= lb_n;
      wa_r           <= wa_n;
      wb_r           <= wb_n;
      out_r.label_a  <= (ia_r == ib_r) ? lb_n : la_n;
      out_r.label_b  <= lb_n;
      out_r.joined   <= near;
      out_r.merged   <= sweep_n;
      out_r.last_out <= last_r;
    end
    if (cmd.sweep) begin
      swa_r <= sw_r[ITEM_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_join_same_label: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.deliver && out_r.joined) |-> (out_r.label_a == out_r.label_b))
    else $error("joined endpoints carry different labels");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |=> (LABEL_W'(cnt_r - $past(cnt_r)) <= LABEL_W'(2)))
    else $error("label counter advanced by more than two");
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_a && wa_r) |=> valid_r[ia_r])
    else $error("written item not marked valid");
  a_merge_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && sweep_n) |=> (sw_r == '0))
    else $error("sweep counter not cleared at merge");
`endif

endmodule
